[hw/rtl/scml_pkg.sv]
// Shared types and constants for the serial command memory loader.
`default_nettype none

package scml_pkg;

  localparam int unsigned WINDOW_BYTES  = 8;
  localparam int unsigned WINDOW_W      = WINDOW_BYTES * 8;
  localparam int unsigned CHUNK_BYTES_D = 64;
  localparam int unsigned CHUNK_W       = 8;

  // Command words, oldest byte in the top bits of the window.
  localparam logic [WINDOW_W-1:0] CMD_MEM_LOAD  = 64'h4541_5359_4D45_4D43; // EASYMEMC
  localparam logic [WINDOW_W-1:0] CMD_PROG_LOAD = 64'h4541_5359_5052_4F47; // EASYPROG

  localparam logic TARGET_CTRL_MEM = 1'b0;
  localparam logic TARGET_PROG_MEM = 1'b1;

  typedef enum logic [1:0] {
    MODE_WAIT_CMD,
    MODE_WAIT_LEN,
    MODE_RECV,
    MODE_HALT
  } mode_t;

  typedef struct packed {
    logic mem_hit;
    logic prog_hit;
  } cmd_hit_t;

  typedef struct packed {
    logic        valid;
    logic        mem_write;
    logic        write_target;
    logic [31:0] write_offset;
    logic [7:0]  write_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        controller_stop;
    logic        controller_start;
    logic        program_loaded;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/serial_command_memory_loader.sv]
// Serial command memory loader top level with the result register.
//
// Usage: received serial bytes enter on the in_ channel (in_valid/in_stall).
// While waiting for a command the block watches the last eight bytes for
// EASYMEMC (memory load, reports controller_stop) or EASYPROG (program load).
// Four big-endian length bytes follow; the fourth returns a credit byte of
// CHUNK_BYTES on tx_byte. Each payload byte then comes out as a write with a
// rising offset, and a credit follows every full chunk that is not the last.
// A finished memory load reports controller_start and waits for the next
// command; a finished program load reports program_loaded and ignores all
// further bytes until reset.
// Bytes that produce nothing (command bytes, the first three length bytes)
// give no out_ transaction.
// out_valid rises in the cycle after the input transaction. Throughput: one byte
// per cycle, set by the single result register; a byte is accepted while a
// result waits only if that result is taken in the same cycle.
// Reset: synchronous, active low; clears the window to zeros and returns to
// waiting for a command. While out_stall holds with a result waiting, the result
// holds and in_stall rises.
`default_nettype none

module serial_command_memory_loader #(
  parameter int unsigned CHUNK_BYTES = scml_pkg::CHUNK_BYTES_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_mem_write,
  output logic             out_write_target,
  output logic [31:0]      out_write_offset,
  output logic [7:0]       out_write_data,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_controller_stop,
  output logic             out_controller_start,
  output logic             out_program_loaded
);
  import scml_pkg::*;

  logic     accept;
  logic     shift_en;
  cmd_hit_t hit;
  result_t  res;
  result_t  out_r;
  logic     out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  scml_cmd_detect u_detect (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .rx_byte  (in_rx_byte),
    .hit      (hit)
  );

  scml_loader #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_loader (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .hit      (hit),
    .shift_en (shift_en),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && res.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload only when a new result arrives; hold it otherwise.
  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mem_write        = out_r.mem_write;
  assign out_write_target     = out_r.write_target;
  assign out_write_offset     = out_r.write_offset;
  assign out_write_data       = out_r.write_data;
  assign out_tx_valid         = out_r.tx_valid;
  assign out_tx_byte          = out_r.tx_byte;
  assign out_controller_stop  = out_r.controller_stop;
  assign out_controller_start = out_r.controller_start;
  assign out_program_loaded   = out_r.program_loaded;

endmodule

`default_nettype wire

[hw/rtl/scml_cmd_detect.sv]
// Command window shift register and command word compare.
`default_nettype none

module scml_cmd_detect (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire logic [7:0]        rx_byte,
  output scml_pkg::cmd_hit_t     hit
);
  import scml_pkg::*;

  logic [WINDOW_W-1:0] window_r;
  logic [WINDOW_W-1:0] window_nxt;

  assign window_nxt = {window_r[WINDOW_W-9:0], rx_byte};

  // Compare against the window as it stands after this byte shifts in.
  assign hit.mem_hit  = (window_nxt == CMD_MEM_LOAD);
  assign hit.prog_hit = (window_nxt == CMD_PROG_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (shift_en) begin
      window_r <= window_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/scml_loader.sv]
// Load sequencer: length capture, payload offsets, chunk credits and completion.
`default_nettype none

module scml_loader #(
  parameter int unsigned CHUNK_BYTES = scml_pkg::CHUNK_BYTES_D
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          rx_byte,
  input  wire scml_pkg::cmd_hit_t  hit,
  output logic                     shift_en,
  output scml_pkg::result_t        res
);
  import scml_pkg::*;

  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_BYTES);

  mode_t              mode_r, mode_nxt;
  logic               target_r, target_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [31:0]        cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [1:0]         seen_r, seen_nxt;

  logic [31:0]        cnt_inc;
  logic [CHUNK_W-1:0] chunk_inc;
  logic [31:0]        len_shift;

  assign shift_en  = accept && (mode_r == MODE_WAIT_CMD);
  assign cnt_inc   = cnt_r + 32'd1;
  assign chunk_inc = chunk_r + CHUNK_W'(1);
  assign len_shift = {len_r[23:0], rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WAIT_CMD;
      target_r <= TARGET_CTRL_MEM;
      len_r    <= '0;
      cnt_r    <= '0;
      chunk_r  <= '0;
      seen_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      chunk_r  <= chunk_nxt;
      seen_r   <= seen_nxt;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    target_nxt = target_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    chunk_nxt  = chunk_r;
    seen_nxt   = seen_r;
    res        = '0;

    if (accept) begin
      case (mode_r)
        MODE_WAIT_CMD: begin
          if (hit.mem_hit || hit.prog_hit) begin
            target_nxt = hit.mem_hit ? TARGET_CTRL_MEM : TARGET_PROG_MEM;
            mode_nxt   = MODE_WAIT_LEN;
            len_nxt    = '0;
            cnt_nxt    = '0;
            chunk_nxt  = '0;
            seen_nxt   = '0;
          end
          if (hit.mem_hit) begin
            res.valid           = 1'b1;
            res.controller_stop = 1'b1;
          end
        end
        MODE_WAIT_LEN: begin
          len_nxt = len_shift;
          if (seen_r != 2'd3) begin
            seen_nxt = seen_r + 2'd1;
          end else begin
            seen_nxt     = '0;
            cnt_nxt      = '0;
            chunk_nxt    = '0;
            mode_nxt     = MODE_RECV;
            res.valid    = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_byte  = CHUNK_LAST;
            // Zero length finishes together with the first credit.
            if (len_shift == '0) begin
              if (target_r == TARGET_PROG_MEM) begin
                res.program_loaded = 1'b1;
                mode_nxt           = MODE_HALT;
              end else begin
                res.controller_start = 1'b1;
                mode_nxt             = MODE_WAIT_CMD;
              end
            end
          end
        end
        MODE_RECV: begin
          res.valid        = 1'b1;
          res.mem_write    = 1'b1;
          res.write_target = target_r;
          res.write_offset = cnt_r;
          res.write_data   = rx_byte;
          cnt_nxt          = cnt_inc;
          chunk_nxt        = chunk_inc;
          if (cnt_inc >= len_r) begin
            if (target_r == TARGET_PROG_MEM) begin
              res.program_loaded = 1'b1;
              mode_nxt           = MODE_HALT;
            end else begin
              res.controller_start = 1'b1;
              mode_nxt             = MODE_WAIT_CMD;
            end
          end else if (chunk_inc == CHUNK_LAST) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = CHUNK_LAST;
            chunk_nxt    = '0;
          end
        end
        default: begin
          // Halted: drop every byte until reset.
        end
      endcase
    end
  end

endmodule

`default_nettype wire
